// ===== hdl/ocrf_pkg.sv =====
// Shared types, constants and tables for the CAN response text formatter.
// No dependencies; every other file in hdl/ imports this package.
package ocrf_pkg;

    localparam int unsigned TICK_W      = 3;
    localparam logic [TICK_W-1:0] WAIT_TICKS = 3'd4;
    localparam int unsigned Q_DEPTH     = 2;
    localparam int unsigned Q_PTR_W     = 1;
    localparam int unsigned PC_W        = 6;
    localparam int unsigned APB_AW      = 4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] REG_SHOW_HEADERS = 2'd0;
    localparam logic [1:0] REG_PRINT_SPACES = 2'd1;
    localparam logic [1:0] REG_ADD_LINEFEED = 2'd2;

    localparam logic [7:0] ID_MATCH    = 8'hFD;
    localparam logic [7:0] FLOW_ID_HI  = 8'hFC;
    localparam logic [3:0] PCI_FIRST   = 4'h1;
    localparam logic [3:0] PCI_CONSEC  = 4'h2;
    localparam logic [3:0] FRAME_LEN_8 = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [28:0] can_id;
        logic        extended;
        logic [3:0]  frame_len;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_char;
        logic [10:0] flow_id;
        logic        last;
    } t_result;

    typedef struct packed {
        logic show_headers;
        logic print_spaces;
        logic add_linefeed;
    } t_cfg;

    typedef enum logic [2:0] {
        CMD_SINGLE,
        CMD_FIRST,
        CMD_CONSEC,
        CMD_NODATA,
        CMD_CLOSE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind       kind;
        logic [28:0]     addr;
        logic            ext;
        logic [7:0][7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        TOK_LIT,
        TOK_SPC,
        TOK_NIB,
        TOK_FLOW,
        TOK_IDENT,
        TOK_BYTES
    } t_tok_op;

    typedef struct packed {
        t_tok_op    op;
        logic [7:0] ch;
        logic [2:0] first;
        logic [2:0] stop;
        logic       to_d0;
        logic       last;
    } t_tok;

    localparam logic [PC_W-1:0] PC_SINGLE_H = 6'd0;
    localparam logic [PC_W-1:0] PC_SINGLE_N = 6'd5;
    localparam logic [PC_W-1:0] PC_FIRST_N  = 6'd9;
    localparam logic [PC_W-1:0] PC_FIRST_H  = 6'd18;
    localparam logic [PC_W-1:0] PC_CONS_N   = 6'd22;
    localparam logic [PC_W-1:0] PC_CONS_H   = 6'd27;
    localparam logic [PC_W-1:0] PC_NODATA   = 6'd30;
    localparam logic [PC_W-1:0] PC_CLOSE    = 6'd40;

    function automatic t_tok mk_tok(t_tok_op op, logic [7:0] ch, logic [2:0] first,
                                    logic [2:0] stop, logic to_d0, logic last);
        t_tok t;
        t.op    = op;
        t.ch    = ch;
        t.first = first;
        t.stop  = stop;
        t.to_d0 = to_d0;
        t.last  = last;
        return t;
    endfunction

    function automatic t_tok lit(logic [7:0] ch, logic last);
        return mk_tok(TOK_LIT, ch, 3'd0, 3'd0, 1'b0, last);
    endfunction

    function automatic t_tok tok_rom(logic [PC_W-1:0] pc);
        t_tok t;
        case (pc)
            6'd0:  t = mk_tok(TOK_IDENT, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd1:  t = mk_tok(TOK_BYTES, CH_NUL, 3'd0, 3'd0, 1'b1, 1'b0);
            6'd2:  t = lit(CH_CR, 1'b0);
            6'd3:  t = lit(CH_CR, 1'b0);
            6'd4:  t = lit(CH_GT, 1'b1);
            6'd5:  t = mk_tok(TOK_BYTES, CH_NUL, 3'd1, 3'd0, 1'b1, 1'b0);
            6'd6:  t = lit(CH_CR, 1'b0);
            6'd7:  t = lit(CH_CR, 1'b0);
            6'd8:  t = lit(CH_GT, 1'b1);
            6'd9:  t = mk_tok(TOK_NIB, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd10: t = mk_tok(TOK_BYTES, CH_NUL, 3'd1, 3'd1, 1'b0, 1'b0);
            6'd11: t = lit(CH_CR, 1'b0);
            6'd12: t = lit(CH_ZERO, 1'b0);
            6'd13: t = lit(CH_COLON, 1'b0);
            6'd14: t = mk_tok(TOK_SPC, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd15: t = mk_tok(TOK_BYTES, CH_NUL, 3'd2, 3'd7, 1'b0, 1'b0);
            6'd16: t = mk_tok(TOK_FLOW, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd17: t = lit(CH_CR, 1'b1);
            6'd18: t = mk_tok(TOK_IDENT, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd19: t = mk_tok(TOK_BYTES, CH_NUL, 3'd0, 3'd7, 1'b0, 1'b0);
            6'd20: t = mk_tok(TOK_FLOW, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd21: t = lit(CH_CR, 1'b1);
            6'd22: t = mk_tok(TOK_NIB, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd23: t = lit(CH_COLON, 1'b0);
            6'd24: t = mk_tok(TOK_SPC, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd25: t = mk_tok(TOK_BYTES, CH_NUL, 3'd1, 3'd7, 1'b0, 1'b0);
            6'd26: t = lit(CH_CR, 1'b1);
            6'd27: t = mk_tok(TOK_IDENT, CH_NUL, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd28: t = mk_tok(TOK_BYTES, CH_NUL, 3'd0, 3'd7, 1'b0, 1'b0);
            6'd29: t = lit(CH_CR, 1'b1);
            6'd30: t = lit(CH_N, 1'b0);
            6'd31: t = lit(CH_O, 1'b0);
            6'd32: t = lit(CH_SP, 1'b0);
            6'd33: t = lit(CH_D, 1'b0);
            6'd34: t = lit(CH_A, 1'b0);
            6'd35: t = lit(CH_T, 1'b0);
            6'd36: t = lit(CH_A, 1'b0);
            6'd37: t = lit(CH_CR, 1'b0);
            6'd38: t = lit(CH_CR, 1'b0);
            6'd39: t = lit(CH_GT, 1'b1);
            6'd40: t = lit(CH_CR, 1'b0);
            6'd41: t = lit(CH_GT, 1'b1);
            default: t = lit(CH_NUL, 1'b1);
        endcase
        return t;
    endfunction

    function automatic logic [PC_W-1:0] prog_start(t_cmd_kind kind, logic hdr);
        logic [PC_W-1:0] pc;
        case (kind)
            CMD_SINGLE: pc = hdr ? PC_SINGLE_H : PC_SINGLE_N;
            CMD_FIRST:  pc = hdr ? PC_FIRST_H : PC_FIRST_N;
            CMD_CONSEC: pc = hdr ? PC_CONS_H : PC_CONS_N;
            CMD_NODATA: pc = PC_NODATA;
            CMD_CLOSE:  pc = PC_CLOSE;
            default:    pc = PC_CLOSE;
        endcase
        return pc;
    endfunction

    function automatic logic [2:0] load_idx(t_tok t, logic ext);
        logic [2:0] idx;
        if (t.op == TOK_IDENT) begin
            idx = ext ? 3'd7 : 3'd2;
        end else begin
            idx = t.first;
        end
        return idx;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = CH_ZERO + {4'd0, v};
        end else begin
            c = CH_A + {4'd0, v} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== hdl/ocrf_front.sv =====
// Front end: accepts input items, keeps the wait and multi-frame state and
// turns each item into a formatting command. Depends on ocrf_pkg.
module ocrf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ocrf_pkg::t_item     i_item,
    output logic                o_stall,
    input  logic                i_q_full,
    output logic                o_push,
    output ocrf_pkg::t_cmd      o_cmd
);
    import ocrf_pkg::*;

    logic [TICK_W-1:0] r_ticks_left, n_ticks_left;
    logic              r_in_mf, n_in_mf;
    logic              accept;
    logic              id_ok;
    logic [7:0]        d0;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign d0      = i_item.byte0;
    assign id_ok   = (i_item.can_id[10:3] == ID_MATCH) && (i_item.frame_len == FRAME_LEN_8);

    always_comb begin
        n_ticks_left = r_ticks_left;
        n_in_mf      = r_in_mf;
        o_push       = 1'b0;
        o_cmd.kind   = CMD_CLOSE;
        o_cmd.addr   = i_item.extended ? i_item.can_id : {18'd0, i_item.can_id[10:0]};
        o_cmd.ext    = i_item.extended;
        o_cmd.data   = {i_item.byte7, i_item.byte6, i_item.byte5, i_item.byte4,
                        i_item.byte3, i_item.byte2, i_item.byte1, i_item.byte0};
        if (accept) begin
            case (i_item.opcode)
                OP_START: begin
                    n_ticks_left = WAIT_TICKS;
                end
                OP_FRAME: begin
                    if (r_ticks_left != '0 && id_ok) begin
                        if (d0 <= 8'd7) begin
                            n_ticks_left = '0;
                            o_push       = 1'b1;
                            o_cmd.kind   = CMD_SINGLE;
                        end else if (d0[7:4] == PCI_FIRST) begin
                            n_in_mf    = 1'b1;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_FIRST;
                        end else if (r_in_mf && d0[7:4] == PCI_CONSEC) begin
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_CONSEC;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_ticks_left != '0) begin
                        n_ticks_left = r_ticks_left - 1'b1;
                        if (r_ticks_left == TICK_W'(1)) begin
                            o_push     = 1'b1;
                            o_cmd.kind = r_in_mf ? CMD_CLOSE : CMD_NODATA;
                            n_in_mf    = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_left <= '0;
            r_in_mf      <= 1'b0;
        end else begin
            r_ticks_left <= n_ticks_left;
            r_in_mf      <= n_in_mf;
        end
    end

endmodule

// ===== hdl/ocrf_queue.sv =====
// Command queue between front and back end, two register entries deep.
// Depends on ocrf_pkg for the command type and depth.
module ocrf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ocrf_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output ocrf_pkg::t_cmd  o_head
);
    import ocrf_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_count;
    logic               do_push, do_pop;

    assign o_full       = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
        end
    end

endmodule

// ===== hdl/ocrf_back.sv =====
// Back end: walks the token program of the head command and emits at most one
// character or flow-control request per cycle into the output register while
// the output is not stalled. Depends on ocrf_pkg.
module ocrf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ocrf_pkg::t_cfg     i_cfg,
    input  logic               i_cmd_valid,
    input  ocrf_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output ocrf_pkg::t_result  o_result,
    input  logic               i_stall
);
    import ocrf_pkg::*;

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [2:0]      r_idx, n_idx;
    logic [1:0]      r_sub, n_sub;
    logic            r_lf, n_lf;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    t_tok            tok, ntok, stok;
    logic [PC_W-1:0] spc;
    logic            adv, emit, tok_done, byte_end, sp_after;
    logic [31:0]     addr32;
    logic [7:0]      byte_cur;
    logic [3:0]      nib_cur;
    logic [2:0]      stop;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        tok      = tok_rom(r_pc);
        ntok     = tok_rom(r_pc + 1'b1);
        spc      = prog_start(i_cmd.kind, i_cfg.show_headers);
        stok     = tok_rom(spc);
        adv      = !r_out_valid || !i_stall;
        addr32   = {3'd0, i_cmd.addr};
        byte_cur = i_cmd.data[r_idx];
        nib_cur  = addr32[{r_idx, 2'b00} +: 4];
        stop     = tok.to_d0 ? i_cmd.data[0][2:0] : tok.stop;
        sp_after = (r_idx == 3'd0) || (i_cmd.ext && !r_idx[0]);

        n_busy      = r_busy;
        n_pc        = r_pc;
        n_idx       = r_idx;
        n_sub       = r_sub;
        n_lf        = r_lf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        emit        = 1'b0;
        tok_done    = 1'b0;
        byte_end    = 1'b0;
        o_pop       = 1'b0;
        n_out.kind      = 1'b0;
        n_out.text_char = CH_NUL;
        n_out.flow_id   = '0;
        n_out.last      = 1'b0;

        if (!r_busy) begin
            if (i_cmd_valid) begin
                n_busy = 1'b1;
                n_pc   = spc;
                n_idx  = load_idx(stok, i_cmd.ext);
                n_sub  = '0;
                n_lf   = 1'b0;
            end
        end else if (adv) begin
            if (r_lf) begin
                emit            = 1'b1;
                n_out.text_char = CH_LF;
                n_lf            = 1'b0;
                tok_done        = 1'b1;
            end else begin
                case (tok.op)
                    TOK_LIT: begin
                        emit            = 1'b1;
                        n_out.text_char = tok.ch;
                        if (tok.ch == CH_CR && i_cfg.add_linefeed) begin
                            n_lf = 1'b1;
                        end else begin
                            tok_done = 1'b1;
                        end
                    end
                    TOK_SPC: begin
                        emit            = i_cfg.print_spaces;
                        n_out.text_char = CH_SP;
                        tok_done        = 1'b1;
                    end
                    TOK_NIB: begin
                        emit            = 1'b1;
                        n_out.text_char = hex_char(i_cmd.data[0][3:0]);
                        tok_done        = 1'b1;
                    end
                    TOK_FLOW: begin
                        emit          = 1'b1;
                        n_out.kind    = 1'b1;
                        n_out.flow_id = {FLOW_ID_HI, i_cmd.addr[2:0]};
                        tok_done      = 1'b1;
                    end
                    TOK_IDENT: begin
                        emit = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_out.text_char = hex_char(nib_cur);
                            if (sp_after && i_cfg.print_spaces) begin
                                n_sub = 2'd1;
                            end else if (r_idx == 3'd0) begin
                                tok_done = 1'b1;
                            end else begin
                                n_idx = r_idx - 1'b1;
                            end
                        end else begin
                            n_out.text_char = CH_SP;
                            n_sub           = 2'd0;
                            if (r_idx == 3'd0) begin
                                tok_done = 1'b1;
                            end else begin
                                n_idx = r_idx - 1'b1;
                            end
                        end
                    end
                    TOK_BYTES: begin
                        case (r_sub)
                            2'd0: begin
                                if (r_idx > stop) begin
                                    tok_done = 1'b1;
                                end else begin
                                    emit            = 1'b1;
                                    n_out.text_char = hex_char(byte_cur[7:4]);
                                    n_sub           = 2'd1;
                                end
                            end
                            2'd1: begin
                                emit            = 1'b1;
                                n_out.text_char = hex_char(byte_cur[3:0]);
                                if (i_cfg.print_spaces) begin
                                    n_sub = 2'd2;
                                end else begin
                                    byte_end = 1'b1;
                                end
                            end
                            default: begin
                                emit            = 1'b1;
                                n_out.text_char = CH_SP;
                                byte_end        = 1'b1;
                            end
                        endcase
                        if (byte_end) begin
                            n_sub = 2'd0;
                            if (r_idx == stop) begin
                                tok_done = 1'b1;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                    end
                    default: begin
                        tok_done = 1'b1;
                    end
                endcase
            end
            if (tok_done) begin
                if (tok.last) begin
                    n_busy     = 1'b0;
                    o_pop      = 1'b1;
                    n_out.last = 1'b1;
                end else begin
                    n_pc  = r_pc + 1'b1;
                    n_idx = load_idx(ntok, i_cmd.ext);
                    n_sub = 2'd0;
                end
            end
        end

        if (adv) begin
            n_out_valid = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_idx       <= '0;
            r_sub       <= '0;
            r_lf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_idx       <= n_idx;
            r_sub       <= n_sub;
            r_lf        <= n_lf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/obd_can_response_text_formatter_core.sv =====
// Diagnostic CAN response formatter: turns start, frame and tick items into
// hex ASCII text and flow-control requests. An input item is taken whenever
// the two-entry command queue has room, so items may follow back to back.
// The back end then emits at most one result per cycle while the output is
// not stalled: a command gives up to 41 characters or requests (for a
// single frame with a 29-bit header, spaces and line feeds), and it also
// spends steps on its start and on each optional space or empty byte range
// that is left out. The back-end sequencer therefore sets the sustained rate.
// Items that produce no output never reach the back end.
// Depends on ocrf_pkg, ocrf_front, ocrf_queue and ocrf_back.
module obd_can_response_text_formatter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  ocrf_pkg::t_item                 i_item,
    output logic                            o_stall,
    output logic                            o_valid,
    output ocrf_pkg::t_result               o_result,
    input  logic                            i_stall,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ocrf_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ocrf_pkg::*;

    logic       r_show_headers, r_print_spaces, r_add_linefeed;
    logic       cfg_wr;
    t_cfg       cfg;
    logic       q_full, push, pop, head_valid;
    t_cmd       push_cmd, head_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg    = '{show_headers: r_show_headers,
                      print_spaces: r_print_spaces,
                      add_linefeed: r_add_linefeed};

    always_comb begin
        case (paddr[3:2])
            REG_SHOW_HEADERS: prdata = {31'd0, r_show_headers};
            REG_PRINT_SPACES: prdata = {31'd0, r_print_spaces};
            REG_ADD_LINEFEED: prdata = {31'd0, r_add_linefeed};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_headers <= 1'b0;
            r_print_spaces <= 1'b1;
            r_add_linefeed <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SHOW_HEADERS: r_show_headers <= pwdata[0];
                REG_PRINT_SPACES: r_print_spaces <= pwdata[0];
                REG_ADD_LINEFEED: r_add_linefeed <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    ocrf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    ocrf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_cmd)
    );

    ocrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_stall     (i_stall)
    );

endmodule

// ===== verif/tb_obd_can_response_text_formatter_core.sv =====
// Self-checking testbench for obd_can_response_text_formatter_core.
// Drives start, frame, tick and unused-opcode requests, predicts the text and flow-control
// output in-bench and checks every result. Depends on ocrf_pkg and the core.
`timescale 1ns / 1ps

module tb_obd_can_response_text_formatter_core;
    import ocrf_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned LONG_HOLD     = 300;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic        KIND_TEXT     = 1'b0;
    localparam logic        KIND_FLOW     = 1'b1;

    typedef struct {
        t_item item;
        bit    typed;
        string text;
    } t_row;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    t_item        i_item = '0;
    logic         o_stall;
    logic         o_valid;
    t_result      o_result;
    logic         i_stall = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    t_cfg         format_cfg = '{show_headers: 1'b0, print_spaces: 1'b1, add_linefeed: 1'b0};
    logic [TICK_W-1:0] tick_count = '0;
    logic         multi_open = 1'b0;
    string        hex_digits = "0123456789ABCDEF";

    t_result      char_burst[$];
    t_result      pending_text[$];
    t_row         stim_table[$];

    int unsigned  items_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  n_fail = 0;
    int unsigned  cycle_count = 0;
    bit           calm = 1'b0;
    bit           hold_request = 1'b0;

    obd_can_response_text_formatter_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void emit(logic kind, logic [7:0] ch, logic [10:0] fid);
        t_result r;
        r.kind      = kind;
        r.text_char = ch;
        r.flow_id   = fid;
        r.last      = 1'b0;
        char_burst.push_back(r);
    endfunction

    function automatic void emit_char(logic [7:0] ch);
        emit(KIND_TEXT, ch, 11'd0);
        if (ch == CH_CR && format_cfg.add_linefeed) begin
            emit(KIND_TEXT, CH_LF, 11'd0);
        end
    endfunction

    function automatic void emit_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            emit_char(s[k]);
        end
    endfunction

    function automatic void emit_nibble(logic [3:0] v);
        emit_char(hex_digits[v]);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        emit_nibble(b[7:4]);
        emit_nibble(b[3:0]);
        if (format_cfg.print_spaces) begin
            emit_char(" ");
        end
    endfunction

    function automatic void emit_ident(logic [28:0] addr, logic ext);
        if (ext) begin
            emit_byte({3'd0, addr[28:24]});
            emit_byte(addr[23:16]);
            emit_byte(addr[15:8]);
            emit_byte(addr[7:0]);
        end else begin
            emit_nibble({1'b0, addr[10:8]});
            emit_byte(addr[7:0]);
        end
    endfunction

    // Advance the formatter state by one request and leave its output in char_burst.
    function automatic void format_response(t_item it);
        logic [28:0] addr;
        logic [7:0]  d [8];
        char_burst.delete();
        d = '{it.byte0, it.byte1, it.byte2, it.byte3, it.byte4, it.byte5, it.byte6, it.byte7};
        addr = it.extended ? it.can_id : {18'd0, it.can_id[10:0]};
        case (it.opcode)
            OP_START: begin
                tick_count = WAIT_TICKS;
            end
            OP_TICK: begin
                if (tick_count != 0) begin
                    tick_count = tick_count - 1'b1;
                    if (tick_count == 0) begin
                        if (multi_open) begin
                            multi_open = 1'b0;
                        end else begin
                            emit_text("NO DATA\015");
                        end
                        emit_text("\015>");
                    end
                end
            end
            OP_FRAME: begin
                if (tick_count != 0 && addr[10:3] == ID_MATCH && it.frame_len == FRAME_LEN_8) begin
                    if (d[0] <= 8'd7) begin
                        tick_count = '0;
                        if (format_cfg.show_headers) begin
                            emit_ident(addr, it.extended);
                            for (int j = 0; j <= d[0]; j++) emit_byte(d[j]);
                        end else begin
                            for (int j = 1; j <= d[0]; j++) emit_byte(d[j]);
                        end
                        emit_text("\015\015>");
                    end else if (d[0][7:4] == PCI_FIRST) begin
                        multi_open = 1'b1;
                        if (format_cfg.show_headers) begin
                            emit_ident(addr, it.extended);
                            for (int j = 0; j < 8; j++) emit_byte(d[j]);
                        end else begin
                            emit_nibble(d[0][3:0]);
                            emit_byte(d[1]);
                            emit_char(CH_CR);
                            emit_char("0");
                            emit_char(":");
                            if (format_cfg.print_spaces) emit_char(" ");
                            for (int j = 2; j < 8; j++) emit_byte(d[j]);
                        end
                        emit(KIND_FLOW, 8'd0, {FLOW_ID_HI, addr[2:0]});
                        emit_char(CH_CR);
                    end else if (multi_open && d[0][7:4] == PCI_CONSEC) begin
                        if (format_cfg.show_headers) begin
                            emit_ident(addr, it.extended);
                            for (int j = 0; j < 8; j++) emit_byte(d[j]);
                        end else begin
                            emit_nibble(d[0][3:0]);
                            emit_char(":");
                            if (format_cfg.print_spaces) emit_char(" ");
                            for (int j = 1; j < 8; j++) emit_byte(d[j]);
                        end
                        emit_char(CH_CR);
                    end
                end
            end
            default: begin
            end
        endcase
        if (char_burst.size() != 0) begin
            char_burst[$].last = 1'b1;
        end
    endfunction

    function automatic t_item any_item(logic [1:0] op);
        t_item it;
        it.opcode    = op;
        it.can_id    = 29'($urandom);
        it.extended  = 1'($urandom);
        it.frame_len = 4'($urandom_range(0, 8));
        {it.byte0, it.byte1, it.byte2, it.byte3} = $urandom;
        {it.byte4, it.byte5, it.byte6, it.byte7} = $urandom;
        return it;
    endfunction

    function automatic t_item diag_frame(logic [7:0] pci);
        t_item it;
        it = any_item(OP_FRAME);
        it.can_id[10:3] = ID_MATCH;
        it.frame_len    = FRAME_LEN_8;
        it.byte0        = pci;
        return it;
    endfunction

    function automatic t_item broken_frame();
        t_item it;
        it = diag_frame(8'($urandom));
        if ($urandom_range(0, 1) == 1) begin
            it.frame_len = 4'($urandom_range(0, 7));
        end else begin
            it.can_id[3] = ~it.can_id[3];
        end
        return it;
    endfunction

    function automatic void table_row(logic [1:0] op, logic [28:0] id, logic ext,
                                      logic [3:0] len, logic [7:0] pci, logic [7:0] fill,
                                      bit typed, string text);
        t_row r;
        r.item.opcode    = op;
        r.item.can_id    = id;
        r.item.extended  = ext;
        r.item.frame_len = len;
        r.item.byte0     = pci;
        {r.item.byte1, r.item.byte2, r.item.byte3, r.item.byte4,
         r.item.byte5, r.item.byte6, r.item.byte7} = {7{fill}};
        r.typed = typed;
        r.text  = text;
        stim_table.push_back(r);
    endfunction

    task automatic offer(input t_item it, input bit typed = 1'b0, input string text = "");
        i_item  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        format_response(it);
        if (typed) begin
            char_burst.delete();
            for (int k = 0; k < text.len(); k++) emit(KIND_TEXT, text[k], 11'd0);
            if (char_burst.size() != 0) char_burst[$].last = 1'b1;
        end
        foreach (char_burst[k]) pending_text.push_back(char_burst[k]);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain_requests();
        i_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val, input string name);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {31'd0, val}) begin
            $error("%s readback: expected %0d, got %0d", name, val, prdata);
            n_fail++;
        end
    endtask

    task automatic apply_format(input t_cfg c);
        write_reg(REG_SHOW_HEADERS, c.show_headers, "show_headers");
        write_reg(REG_PRINT_SPACES, c.print_spaces, "print_spaces");
        write_reg(REG_ADD_LINEFEED, c.add_linefeed, "add_linefeed");
        psel    <= 1'b0;
        penable <= 1'b0;
        format_cfg = c;
    endtask

    task automatic run_exchange();
        int unsigned pick;
        int unsigned n_cons;
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
            offer(any_item(OP_START));
            if ($urandom_range(0, 1) == 1) offer(any_item(OP_TICK));
            if ($urandom_range(0, 3) != 0) begin
                offer(diag_frame(8'($urandom_range(0, 7))));
                if ($urandom_range(0, 1) == 1) offer(any_item(OP_TICK));
            end else begin
                repeat (4) offer(any_item(OP_TICK));
            end
        end else if (pick <= 7) begin
            offer(any_item(OP_START));
            if (pick == 7) offer(diag_frame({PCI_CONSEC, 4'($urandom)}));
            offer(diag_frame({PCI_FIRST, 4'($urandom)}));
            n_cons = $urandom_range(0, 3);
            repeat (n_cons) begin
                if ($urandom_range(0, 3) == 0) offer(any_item(OP_TICK));
                if ($urandom_range(0, 4) == 0) offer(broken_frame());
                offer(diag_frame({PCI_CONSEC, 4'($urandom)}));
            end
            repeat (4) offer(any_item(OP_TICK));
        end else begin
            repeat ($urandom_range(1, 3)) offer(any_item(2'($urandom)));
        end
    endtask

    initial begin : output_stall
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_text.size() == 0) begin
                $error("unexpected result: kind %0d, text_char %h, flow_id %h",
                       o_result.kind, o_result.text_char, o_result.flow_id);
                n_fail++;
            end else begin
                want = pending_text.pop_front();
                if (o_result.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_result.kind);
                    n_fail++;
                end
                if (o_result.text_char !== want.text_char) begin
                    $error("text_char: expected %h, got %h", want.text_char, o_result.text_char);
                    n_fail++;
                end
                if (o_result.flow_id !== want.flow_id) begin
                    $error("flow_id: expected %h, got %h", want.flow_id, o_result.flow_id);
                    n_fail++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    n_fail++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_cfg format_plan [8];
        int unsigned target;
        format_plan = '{t_cfg'(3'b000), t_cfg'(3'b111), t_cfg'(3'b010), t_cfg'(3'b101),
                        t_cfg'(3'b100), t_cfg'(3'b011), t_cfg'(3'b001), t_cfg'(3'b110)};

        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_FRAME,  29'h7E8,      1'b0, 4'd8, 8'h02, 8'h41, 1'b1, "");
        table_row(OP_UNUSED, 29'h1FFFFFFF, 1'b1, 4'd8, 8'hFF, 8'hFF, 1'b1, "");
        table_row(OP_START,  29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_START,  29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "NO DATA\015\015>");
        table_row(OP_START,  29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_FRAME,  29'h7E8,      1'b0, 4'd7, 8'h02, 8'h11, 1'b1, "");
        table_row(OP_FRAME,  29'h7E0,      1'b0, 4'd8, 8'h02, 8'h11, 1'b1, "");
        table_row(OP_FRAME,  29'h7E8,      1'b0, 4'd8, 8'h21, 8'h11, 1'b1, "");
        table_row(OP_FRAME,  29'h7E8,      1'b0, 4'd8, 8'h30, 8'h11, 1'b1, "");
        table_row(OP_FRAME,  29'h1FFFFFEF, 1'b0, 4'd8, 8'h00, 8'hFF, 1'b1, "\015\015>");
        table_row(OP_START,  29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_FRAME,  29'h7EF,      1'b0, 4'd8, 8'h1F, 8'hFF, 1'b0, "");
        table_row(OP_FRAME,  29'h7EF,      1'b0, 4'd8, 8'h20, 8'h00, 1'b0, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_TICK,   29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "\015>");
        table_row(OP_START,  29'h0,        1'b0, 4'd0, 8'h00, 8'h00, 1'b1, "");
        table_row(OP_FRAME,  29'h1FFFFFEF, 1'b1, 4'd8, 8'h07, 8'hC3, 1'b0, "");

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            offer(stim_table[k].item, stim_table[k].typed, stim_table[k].text);
        end
        drain_requests();

        for (int p = 0; p < 8; p++) begin
            apply_format(format_plan[p]);
            calm = (p == 7);
            if (p == 1) hold_request = 1'b1;
            target = items_sent + 14;
            while (items_sent < target) run_exchange();
            drain_requests();
        end

        $display("Sent %0d requests: directed table, then eight output formats of random exchanges.",
                 items_sent);
        $display("Checked %0d characters and flow-control requests, one long output hold-off.",
                 results_seen);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
